FILE: hw/rtl/csdm_pkg.sv
// Shared types, constants and tables for the concentric square-to-disk mapper.
package csdm_pkg;

    localparam int SAMPLE_BITS_DEF      = 16;
    localparam int ANGLE_ITERATIONS_DEF = 16;
    localparam int QUEUE_DEPTH          = 4;
    localparam int QUEUE_AW             = 2;
    localparam int VEC_W                = 34;
    localparam int ANG_W                = 32;
    localparam int DIV_W                = 30;
    localparam int OUT_W                = 16;
    localparam logic [31:0] CORDIC_GAIN = 32'h9B74EDA8;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // One classified sample: radius (raw magnitude), ratio operands and sector data.
    typedef struct packed {
        logic [32:0] r;
        logic [32:0] num_mag;
        logic [32:0] den_mag;
        logic        neg;
        quad_t       quad;
    } work_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0: v = 32'h20000000;   5'd1: v = 32'h12E4051E;
                5'd2: v = 32'h09FB385B;   5'd3: v = 32'h051111D4;
                5'd4: v = 32'h028B0D43;   5'd5: v = 32'h0145D7E1;
                5'd6: v = 32'h00A2F61E;   5'd7: v = 32'h00517C55;
                5'd8: v = 32'h0028BE53;   5'd9: v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
                5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
                5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
                5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
                5'd30: v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: hw/rtl/concentric_square_to_disk_map_top.sv
// Path to done: front register, the queue, then 50 back end registers (at 16 CORDIC stages).
// Back end: divider input + 30 divider stages + angle sign + gain + CORDIC stages + output.
// Throughput: one sample per cycle; busy never rises as the back end never stalls.
// Reset (rst_n low, asynchronous) empties the queue and clears every valid bit.
// Results appear on done for one cycle; the receiver cannot stall.
module concentric_square_to_disk_map_top #(
    parameter int SAMPLE_BITS      = csdm_pkg::SAMPLE_BITS_DEF,
    parameter int ANGLE_ITERATIONS = csdm_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] sample_u,
    input  logic [15:0] sample_v,
    output logic        done,
    output logic signed [15:0] disk_x,
    output logic signed [15:0] disk_y
);

    logic            f_valid, q_ne, q_full, accept;
    csdm_pkg::work_t f_work, q_head;
    logic [15:0]     ox, oy;

    assign busy   = q_full;
    assign accept = start && !busy;

    csdm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(accept),
        .u(SAMPLE_BITS'(sample_u)), .v(SAMPLE_BITS'(sample_v)),
        .out_valid(f_valid), .out_work(f_work)
    );

    csdm_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(f_valid), .push_data(f_work),
        .pop(q_ne), .not_empty(q_ne), .full(q_full), .head(q_head)
    );

    csdm_back #(.SAMPLE_BITS(SAMPLE_BITS), .ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(q_ne), .in_work(q_head),
        .out_valid(done), .out_x(ox), .out_y(oy)
    );

    assign disk_x = $signed(ox);
    assign disk_y = $signed(oy);

endmodule

FILE: hw/rtl/csdm_front.sv
// Front end: remap a square sample to [-1,1) and classify it into a sector.
module csdm_front #(
    parameter int SAMPLE_BITS = csdm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [SAMPLE_BITS-1:0] u,
    input  logic [SAMPLE_BITS-1:0] v,
    output logic                   out_valid,
    output csdm_pkg::work_t        out_work
);

    logic signed [SAMPLE_BITS+1:0] x, y;
    logic [SAMPLE_BITS+1:0]        ax, ay;
    csdm_pkg::work_t               w;
    logic                          valid_reg;
    csdm_pkg::work_t               work_reg;

    always_comb
    begin
        x  = $signed({1'b0, u, 1'b0}) - $signed((SAMPLE_BITS+2)'(1) <<< SAMPLE_BITS);
        y  = $signed({1'b0, v, 1'b0}) - $signed((SAMPLE_BITS+2)'(1) <<< SAMPLE_BITS);
        ax = x[SAMPLE_BITS+1] ? (SAMPLE_BITS+2)'(-x) : x;
        ay = y[SAMPLE_BITS+1] ? (SAMPLE_BITS+2)'(-y) : y;
        w  = '0;
        if (x > -y) begin
            if (x > y) begin
                w.quad = csdm_pkg::QUAD_0; w.r = 33'(ax);
                w.num_mag = 33'(ay); w.den_mag = 33'(ax);
                w.neg = y[SAMPLE_BITS+1] ^ x[SAMPLE_BITS+1];
            end
            else begin
                w.quad = csdm_pkg::QUAD_1; w.r = 33'(ay);
                w.num_mag = 33'(ax); w.den_mag = 33'(ay);
                w.neg = ~(x[SAMPLE_BITS+1] ^ y[SAMPLE_BITS+1]);
            end
        end
        else begin
            if (x < y) begin
                w.quad = csdm_pkg::QUAD_2; w.r = 33'(ax);
                w.num_mag = 33'(ay); w.den_mag = 33'(ax);
                w.neg = y[SAMPLE_BITS+1] ^ x[SAMPLE_BITS+1];
            end
            else begin
                w.quad = csdm_pkg::QUAD_3; w.r = 33'(ay);
                w.num_mag = 33'(ax); w.den_mag = 33'(ay);
                w.neg = ~(x[SAMPLE_BITS+1] ^ y[SAMPLE_BITS+1]);
            end
        end
        // a zero numerator gives zero angle whatever the sign
        if (w.num_mag == '0) w.neg = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else        valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid) work_reg <= w;
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

FILE: hw/rtl/csdm_queue.sv
// Short transaction queue between the front end and the back end.
module csdm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  csdm_pkg::work_t push_data,
    input  logic            pop,
    output logic            not_empty,
    output logic            full,
    output csdm_pkg::work_t head
);

    localparam int AW = csdm_pkg::QUEUE_AW;

    csdm_pkg::work_t mem [csdm_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   wptr_reg, rptr_reg;
    logic [AW:0]     count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg <= '0; rptr_reg <= '0; count_reg <= '0;
        end
        else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem[wptr_reg] <= push_data;
    end

    assign head      = mem[rptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (AW+1)'(csdm_pkg::QUEUE_DEPTH));

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("queue underflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(csdm_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

FILE: hw/rtl/csdm_back.sv
// Back end: pipelined divider, gain multiply, CORDIC stages, sector fold and rounding.
module csdm_back #(
    parameter int SAMPLE_BITS      = csdm_pkg::SAMPLE_BITS_DEF,
    parameter int ANGLE_ITERATIONS = csdm_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  csdm_pkg::work_t         in_work,
    output logic                    out_valid,
    output logic [csdm_pkg::OUT_W-1:0] out_x,
    output logic [csdm_pkg::OUT_W-1:0] out_y
);

    localparam int DW = csdm_pkg::DIV_W;   // quotient bits 29..0
    localparam int VW = csdm_pkg::VEC_W;
    localparam int AW = csdm_pkg::ANG_W;
    localparam int N  = ANGLE_ITERATIONS;

    // divider stage: restoring, one quotient bit a stage, MSB first
    logic [DW:0]           d_v;
    logic [33:0]           d_rem  [DW+1];
    logic [32:0]           d_den  [DW+1];
    logic [DW-1:0]         d_q    [DW+1];
    logic [32:0]           d_r    [DW+1];
    logic                  d_neg  [DW+1];
    logic                  d_zero [DW+1];
    csdm_pkg::quad_t       d_quad [DW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) d_v <= '0;
        else        d_v <= {d_v[DW-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        d_rem[0]  <= {1'b0, in_work.num_mag};
        d_den[0]  <= in_work.den_mag;
        d_q[0]    <= '0;
        d_r[0]    <= in_work.r;
        d_neg[0]  <= in_work.neg;
        d_zero[0] <= (in_work.den_mag == '0);
        d_quad[0] <= in_work.quad;
    end

    // first stage gives the integer bit; later stages double the remainder before the test
    for (genvar k = 0; k < DW; k++) begin : g_div
        logic [33:0] tr;
        logic        ge;
        assign tr = (k == 0) ? d_rem[k] : {d_rem[k][32:0], 1'b0};
        assign ge = (tr >= {1'b0, d_den[k]});
        always_ff @(posedge clk)
        begin
            d_rem[k+1]  <= ge ? (tr - {1'b0, d_den[k]}) : tr;
            d_q[k+1]    <= d_q[k] | (ge ? (DW'(1) << (DW-1-k)) : '0);
            d_den[k+1]  <= d_den[k];
            d_r[k+1]    <= d_r[k];
            d_neg[k+1]  <= d_neg[k];
            d_zero[k+1] <= d_zero[k];
            d_quad[k+1] <= d_quad[k];
        end
    end

    logic signed [AW:0] z_a;
    logic               v_a;
    csdm_pkg::quad_t    quad_a;
    logic [63:0]        r30;
    logic [31:0]        r30_reg;

    always_comb
    begin
        if (SAMPLE_BITS <= 30) r30 = 64'(d_r[DW]) << (30 - SAMPLE_BITS);
        else                   r30 = 64'(d_r[DW]) >> (SAMPLE_BITS - 30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_a <= 1'b0;
        else        v_a <= d_v[DW];
    end
    // apply the ratio sign; a zero denominator (origin) gives zero angle
    always_ff @(posedge clk)
    begin
        z_a     <= d_zero[DW] ? '0 :
                   (d_neg[DW] ? -$signed({3'b000, d_q[DW]}) : $signed({3'b000, d_q[DW]}));
        r30_reg <= 32'(r30);
        quad_a  <= d_quad[DW];
    end

    // gain multiply and round to Q.30
    logic [63:0]     prod;
    logic signed [VW-1:0] cx0;
    logic signed [AW:0]   z_b;
    csdm_pkg::quad_t      quad_b;
    logic                 v_b;
    assign prod = 64'(r30_reg) * 64'(csdm_pkg::CORDIC_GAIN) + 64'h80000000;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_b <= 1'b0;
        else        v_b <= v_a;
    end
    always_ff @(posedge clk)
    begin
        cx0    <= $signed(VW'(prod[63:32]));
        z_b    <= z_a;
        quad_b <= quad_a;
    end

    // CORDIC stages
    logic signed [VW-1:0] cx [N+1];
    logic signed [VW-1:0] cy [N+1];
    logic signed [AW+1:0] zz [N+1];
    csdm_pkg::quad_t      cq [N+1];
    logic                 cv [N+1];
    assign cx[0] = cx0;
    assign cy[0] = '0;
    assign zz[0] = (AW+2)'(z_b);
    assign cq[0] = quad_b;
    assign cv[0] = v_b;

    for (genvar i = 0; i < N; i++) begin : g_cordic
        logic signed [VW-1:0] dx, dy;
        logic signed [AW+1:0] a;
        assign dx = cy[i] >>> i;
        assign dy = cx[i] >>> i;
        assign a  = $signed({2'b00, csdm_pkg::atan_entry(5'(i))});
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) cv[i+1] <= 1'b0;
            else        cv[i+1] <= cv[i];
        end
        always_ff @(posedge clk)
        begin
            if (!zz[i][AW+1]) begin
                cx[i+1] <= cx[i] - dx; cy[i+1] <= cy[i] + dy; zz[i+1] <= zz[i] - a;
            end
            else begin
                cx[i+1] <= cx[i] + dx; cy[i+1] <= cy[i] - dy; zz[i+1] <= zz[i] + a;
            end
            cq[i+1] <= cq[i];
        end
    end

    // sector fold and conversion to Q1.15
    function automatic logic [15:0] to_q15(input logic signed [VW:0] v30);
        logic signed [VW:0] t;
        begin
            t = (v30 + (VW+1)'(16384)) >>> 15;
            if (t > 32767)       return 16'h7FFF;
            else if (t < -32768) return 16'h8000;
            else                 return t[15:0];
        end
    endfunction

    logic signed [VW:0] fx, fy;
    always_comb
    begin
        unique case (cq[N])
            csdm_pkg::QUAD_1: begin fx = -(VW+1)'(cy[N]); fy = (VW+1)'(cx[N]); end
            csdm_pkg::QUAD_2: begin fx = -(VW+1)'(cx[N]); fy = -(VW+1)'(cy[N]); end
            csdm_pkg::QUAD_3: begin fx = (VW+1)'(cy[N]);  fy = -(VW+1)'(cx[N]); end
            default:          begin fx = (VW+1)'(cx[N]);  fy = (VW+1)'(cy[N]); end
        endcase
    end

    logic            ov_reg;
    logic [15:0]     ox_reg, oy_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) ov_reg <= 1'b0;
        else        ov_reg <= cv[N];
    end
    always_ff @(posedge clk)
    begin
        ox_reg <= to_q15(fx);
        oy_reg <= to_q15(fy);
    end

    assign out_valid = ov_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;

    assert property (@(posedge clk) disable iff (!rst_n) v_b |=> cv[1])
        else $error("cordic entry lost");
    assert property (@(posedge clk) disable iff (!rst_n) cv[N] |=> ov_reg)
        else $error("result strobe lost");
    assert property (@(posedge clk) disable iff (!rst_n) in_valid |=> d_v[0])
        else $error("divider entry lost");

endmodule
